### hw/rtl/tmc_pkg.sv
// Package for the tile mean color unit: widths, register codes, FSM states
// and the structs passed between the controller, the lanes and the register file.
// No dependencies.
`default_nettype none

package tmc_pkg;

  localparam int PIX_W         = 8;
  localparam int SUM_W         = 20;
  localparam int DIM_W         = 6;
  localparam int CFG_DIM_W     = 7;
  localparam int COL_W         = 9;
  localparam int CFG_CNT_W     = 10;
  localparam int AREA_W        = 13;
  localparam int MAX_TILE_COLS = 512;
  localparam int MAX_TILE_DIM  = 64;
  localparam int ROW_LIMIT     = 512;
  localparam int LANES         = 4;
  localparam int QUO_W         = PIX_W + 1;
  localparam int DIV_STEPS     = QUO_W;
  localparam int STEP_W        = $clog2(DIV_STEPS);
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  typedef enum logic [1:0] {
    REG_TILE_WIDTH  = 2'd0,
    REG_TILE_HEIGHT = 2'd1,
    REG_TILE_COLS   = 2'd2,
    REG_TILE_ROWS   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] tile_width;
    logic [CFG_DIM_W-1:0] tile_height;
    logic [CFG_CNT_W-1:0] tile_cols;
    logic [CFG_CNT_W-1:0] tile_rows;
  } cfg_t;

  typedef struct packed {
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    logic              fresh;
    logic              div_start;
    logic              div_step;
    logic [AREA_W-1:0] area;
  } lane_ctl_t;

  typedef struct packed {
    logic [COL_W-1:0] tile_column;
    logic [COL_W-1:0] tile_row;
    logic             frame_done;
  } tile_info_t;

endpackage

`default_nettype wire

### hw/rtl/tmc_if.sv
// Valid/ready channel interfaces for pixel items in and tile items out.
// Depends on tmc_pkg.
`default_nettype none

interface tmc_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [tmc_pkg::PIX_W-1:0] red;
  logic [tmc_pkg::PIX_W-1:0] green;
  logic [tmc_pkg::PIX_W-1:0] blue;
  logic [tmc_pkg::PIX_W-1:0] alpha;
  logic                      frame_start;

  modport source (output valid, red, green, blue, alpha, frame_start, input ready);
  modport sink   (input valid, red, green, blue, alpha, frame_start, output ready);
endinterface

interface tmc_tile_if;
  logic                      valid;
  logic                      ready;
  logic [tmc_pkg::COL_W-1:0] tile_column;
  logic [tmc_pkg::COL_W-1:0] tile_row;
  logic [tmc_pkg::PIX_W-1:0] mean_red;
  logic [tmc_pkg::PIX_W-1:0] mean_green;
  logic [tmc_pkg::PIX_W-1:0] mean_blue;
  logic [tmc_pkg::PIX_W-1:0] mean_alpha;
  logic                      frame_done;

  modport source (output valid, tile_column, tile_row, mean_red, mean_green, mean_blue,
                  mean_alpha, frame_done, input ready);
  modport sink   (input valid, tile_column, tile_row, mean_red, mean_green, mean_blue,
                  mean_alpha, frame_done, output ready);
endinterface

`default_nettype wire

### hw/rtl/tmc_cfg.sv
// APB-style register file for the tile geometry registers.
// Depends on tmc_pkg.
`default_nettype none

module tmc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tmc_pkg::DATA_W-1:0]  pwdata,
  output logic [tmc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tmc_pkg::cfg_t               cfg
);

  tmc_pkg::cfg_t     regs;
  tmc_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = tmc_pkg::reg_idx_t'(paddr[tmc_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.tile_width  <= tmc_pkg::CFG_DIM_W'(32);
      regs.tile_height <= tmc_pkg::CFG_DIM_W'(32);
      regs.tile_cols   <= tmc_pkg::CFG_CNT_W'(20);
      regs.tile_rows   <= tmc_pkg::CFG_CNT_W'(20);
    end else if (wr) begin
      unique case (idx)
        tmc_pkg::REG_TILE_WIDTH:  regs.tile_width  <= pwdata[tmc_pkg::CFG_DIM_W-1:0];
        tmc_pkg::REG_TILE_HEIGHT: regs.tile_height <= pwdata[tmc_pkg::CFG_DIM_W-1:0];
        tmc_pkg::REG_TILE_COLS:   regs.tile_cols   <= pwdata[tmc_pkg::CFG_CNT_W-1:0];
        tmc_pkg::REG_TILE_ROWS:   regs.tile_rows   <= pwdata[tmc_pkg::CFG_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      tmc_pkg::REG_TILE_WIDTH:  prdata = tmc_pkg::DATA_W'(regs.tile_width);
      tmc_pkg::REG_TILE_HEIGHT: prdata = tmc_pkg::DATA_W'(regs.tile_height);
      tmc_pkg::REG_TILE_COLS:   prdata = tmc_pkg::DATA_W'(regs.tile_cols);
      tmc_pkg::REG_TILE_ROWS:   prdata = tmc_pkg::DATA_W'(regs.tile_rows);
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/tmc_lane.sv
// One channel lane: per-column sum memory, saturating accumulate and a
// restoring divider that gives the saturated floor mean. Depends on tmc_pkg.
`default_nettype none

module tmc_lane (
  input  logic                       clk,
  input  tmc_pkg::lane_ctl_t         ctl,
  input  logic [tmc_pkg::PIX_W-1:0]  px,
  output logic [tmc_pkg::PIX_W-1:0]  mean
);

  logic [tmc_pkg::SUM_W-1:0] mem [tmc_pkg::MAX_TILE_COLS];
  logic [tmc_pkg::SUM_W-1:0] rd_data;
  logic [tmc_pkg::PIX_W-1:0] px_q;
  logic [tmc_pkg::SUM_W:0]   add_full;
  logic [tmc_pkg::SUM_W-1:0] sum;
  logic [tmc_pkg::SUM_W-1:0] rem;
  logic [tmc_pkg::SUM_W:0]   dsh;
  logic [tmc_pkg::QUO_W-1:0] quo;
  logic                      geq;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
      px_q    <= px;
    end
  end

  assign add_full = {1'b0, rd_data} + (tmc_pkg::SUM_W + 1)'(px_q);

  always_comb begin
    if (ctl.fresh) begin
      sum = tmc_pkg::SUM_W'(px_q);
    end else if (add_full[tmc_pkg::SUM_W]) begin
      sum = '1;
    end else begin
      sum = add_full[tmc_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= sum;
    end
  end

  // quotient bit 8 set means the mean saturates
  assign geq = {1'b0, rem} >= dsh;

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      rem <= sum;
      dsh <= {ctl.area, tmc_pkg::PIX_W'(0)};
      quo <= '0;
    end else if (ctl.div_step) begin
      if (geq) begin
        rem <= rem - dsh[tmc_pkg::SUM_W-1:0];
      end
      quo <= {quo[tmc_pkg::QUO_W-2:0], geq};
      dsh <= dsh >> 1;
    end
  end

  assign mean = quo[tmc_pkg::QUO_W-1] ? '1 : quo[tmc_pkg::PIX_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/tmc_ctrl.sv
// Position counters, tile-completion detection and the sequencer that drives
// the channel lanes through accumulate and divide. Depends on tmc_pkg.
`default_nettype none

module tmc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  tmc_pkg::cfg_t          cfg,
  input  logic                   in_valid,
  input  logic                   frame_start,
  output logic                   in_ready,
  input  logic                   out_free,
  output logic                   out_load,
  output tmc_pkg::lane_ctl_t     ctl,
  output tmc_pkg::tile_info_t    info
);

  tmc_pkg::ctrl_state_t state, state_next;

  logic [tmc_pkg::DIM_W-1:0]  pixel_in_tile, line_in_tile;
  logic [tmc_pkg::COL_W-1:0]  current_tile_col, current_tile_row;
  logic [tmc_pkg::DIM_W-1:0]  pit_eff, lit_eff;
  logic [tmc_pkg::COL_W-1:0]  col_eff, row_eff;
  logic [tmc_pkg::DIM_W-1:0]  wm1, hm1;
  logic [tmc_pkg::COL_W-1:0]  ncm1, nrm1;
  logic                       last_px, last_line, last_col, last_row;
  logic                       accept;
  logic [tmc_pkg::STEP_W-1:0] step_cnt;
  logic [tmc_pkg::COL_W-1:0]  col_q;
  logic                       tile_end;
  logic                       fresh_q;
  logic [tmc_pkg::AREA_W-1:0] area_q;
  tmc_pkg::tile_info_t        info_q;

  // clamped limits minus one
  always_comb begin
    if (cfg.tile_width == '0) begin
      wm1 = '0;
    end else if (cfg.tile_width >= tmc_pkg::CFG_DIM_W'(tmc_pkg::MAX_TILE_DIM)) begin
      wm1 = tmc_pkg::DIM_W'(tmc_pkg::MAX_TILE_DIM - 1);
    end else begin
      wm1 = tmc_pkg::DIM_W'(cfg.tile_width - 1'b1);
    end
    if (cfg.tile_height == '0) begin
      hm1 = '0;
    end else if (cfg.tile_height >= tmc_pkg::CFG_DIM_W'(tmc_pkg::MAX_TILE_DIM)) begin
      hm1 = tmc_pkg::DIM_W'(tmc_pkg::MAX_TILE_DIM - 1);
    end else begin
      hm1 = tmc_pkg::DIM_W'(cfg.tile_height - 1'b1);
    end
    if (cfg.tile_cols == '0) begin
      ncm1 = '0;
    end else if (cfg.tile_cols >= tmc_pkg::CFG_CNT_W'(tmc_pkg::MAX_TILE_COLS)) begin
      ncm1 = tmc_pkg::COL_W'(tmc_pkg::MAX_TILE_COLS - 1);
    end else begin
      ncm1 = tmc_pkg::COL_W'(cfg.tile_cols - 1'b1);
    end
    if (cfg.tile_rows == '0) begin
      nrm1 = '0;
    end else if (cfg.tile_rows >= tmc_pkg::CFG_CNT_W'(tmc_pkg::ROW_LIMIT)) begin
      nrm1 = tmc_pkg::COL_W'(tmc_pkg::ROW_LIMIT - 1);
    end else begin
      nrm1 = tmc_pkg::COL_W'(cfg.tile_rows - 1'b1);
    end
  end

  assign in_ready = (state == tmc_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign pit_eff = frame_start ? '0 : pixel_in_tile;
  assign lit_eff = frame_start ? '0 : line_in_tile;
  assign col_eff = frame_start ? '0 : current_tile_col;
  assign row_eff = frame_start ? '0 : current_tile_row;

  assign last_px   = pit_eff >= wm1;
  assign last_line = lit_eff >= hm1;
  assign last_col  = col_eff >= ncm1;
  assign last_row  = row_eff >= nrm1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_in_tile    <= '0;
      line_in_tile     <= '0;
      current_tile_col <= '0;
      current_tile_row <= '0;
    end else if (accept) begin
      if (!last_px) begin
        pixel_in_tile    <= pit_eff + 1'b1;
        line_in_tile     <= lit_eff;
        current_tile_col <= col_eff;
        current_tile_row <= row_eff;
      end else begin
        pixel_in_tile <= '0;
        if (!last_col) begin
          current_tile_col <= col_eff + 1'b1;
          line_in_tile     <= lit_eff;
          current_tile_row <= row_eff;
        end else begin
          current_tile_col <= '0;
          if (!last_line) begin
            line_in_tile     <= lit_eff + 1'b1;
            current_tile_row <= row_eff;
          end else begin
            line_in_tile     <= '0;
            current_tile_row <= last_row ? '0 : row_eff + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_end <= 1'b0;
    end else if (accept) begin
      tile_end <= last_px && last_line;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_q              <= col_eff;
      fresh_q            <= (pit_eff == '0) && (lit_eff == '0);
      area_q             <= (tmc_pkg::AREA_W'(wm1) + 1'b1) * (tmc_pkg::AREA_W'(hm1) + 1'b1);
      info_q.tile_column <= col_eff;
      info_q.tile_row    <= row_eff;
      info_q.frame_done  <= last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tmc_pkg::ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == tmc_pkg::ST_DIV) begin
        step_cnt <= step_cnt + 1'b1;
      end else begin
        step_cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      tmc_pkg::ST_IDLE: if (accept) state_next = tmc_pkg::ST_ACC;
      tmc_pkg::ST_ACC:  state_next = tile_end ? tmc_pkg::ST_DIV : tmc_pkg::ST_IDLE;
      tmc_pkg::ST_DIV: begin
        if (step_cnt == tmc_pkg::STEP_W'(tmc_pkg::DIV_STEPS - 1)) begin
          state_next = tmc_pkg::ST_DONE;
        end
      end
      tmc_pkg::ST_DONE: begin
        out_load = out_free;
        if (out_free) state_next = tmc_pkg::ST_IDLE;
      end
      default: state_next = tmc_pkg::ST_IDLE;
    endcase
  end

  assign ctl.rd_en     = accept;
  assign ctl.rd_addr   = col_eff;
  assign ctl.wr_en     = (state == tmc_pkg::ST_ACC);
  assign ctl.wr_addr   = col_q;
  assign ctl.fresh     = fresh_q;
  assign ctl.div_start = (state == tmc_pkg::ST_ACC) && tile_end;
  assign ctl.div_step  = (state == tmc_pkg::ST_DIV);
  assign ctl.area      = area_q;
  assign info          = info_q;

  a_acc_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == tmc_pkg::ST_ACC)
    else $error("accumulate cycle missing after accepted item");

  a_no_tile_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == tmc_pkg::ST_ACC) && !tile_end |=> state == tmc_pkg::ST_IDLE)
    else $error("non-final pixel did not return to idle");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == tmc_pkg::ST_DIV) && (step_cnt == tmc_pkg::STEP_W'(tmc_pkg::DIV_STEPS - 1))
    |=> state == tmc_pkg::ST_DONE)
    else $error("divide did not finish after its step count");

  a_frame_start_pos: assert property (@(posedge clk) disable iff (rst)
    accept && frame_start |=> (info_q.tile_column == '0) && (info_q.tile_row == '0)
                              && fresh_q)
    else $error("frame start did not reset tile position");

endmodule

`default_nettype wire

### hw/rtl/tile_mean_color_unit.sv
// Tile mean color unit: streamed RGBA pixels in, one mean-color item per tile out.
// Per pixel: read on acceptance, then accumulate/write of the column sum memory.
// A tile's last pixel then runs 9 divide steps and loads the output once it is free.
// Reset clears position counters, FSM and output valid; registers go to 32/32/20/20.
// Sum memories are not cleared: the first pixel of each tile overwrites its column.
`default_nettype none

module tile_mean_color_unit (
  input  logic                        clk,
  input  logic                        rst,
  tmc_pixel_if.sink                   pixel,
  tmc_tile_if.source                  tile,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tmc_pkg::DATA_W-1:0]  pwdata,
  output logic [tmc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  tmc_pkg::cfg_t             cfg;
  tmc_pkg::lane_ctl_t        ctl;
  tmc_pkg::tile_info_t       info;
  logic                      out_free;
  logic                      out_load;
  logic                      out_valid;
  logic [tmc_pkg::PIX_W-1:0] px   [tmc_pkg::LANES];
  logic [tmc_pkg::PIX_W-1:0] mean [tmc_pkg::LANES];
  logic [tmc_pkg::PIX_W-1:0] mean_q [tmc_pkg::LANES];
  tmc_pkg::tile_info_t       info_out;

  tmc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tmc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (pixel.valid),
    .frame_start (pixel.frame_start),
    .in_ready    (pixel.ready),
    .out_free    (out_free),
    .out_load    (out_load),
    .ctl         (ctl),
    .info        (info)
  );

  assign px[0] = pixel.red;
  assign px[1] = pixel.green;
  assign px[2] = pixel.blue;
  assign px[3] = pixel.alpha;

  for (genvar i = 0; i < tmc_pkg::LANES; i++) begin : g_lane
    tmc_lane u_lane (
      .clk  (clk),
      .ctl  (ctl),
      .px   (px[i]),
      .mean (mean[i])
    );
  end

  // merge stage: output register over all lanes
  assign out_free = !out_valid || tile.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (tile.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      info_out <= info;
      for (int i = 0; i < tmc_pkg::LANES; i++) begin
        mean_q[i] <= mean[i];
      end
    end
  end

  assign tile.valid       = out_valid;
  assign tile.tile_column = info_out.tile_column;
  assign tile.tile_row    = info_out.tile_row;
  assign tile.frame_done  = info_out.frame_done;
  assign tile.mean_red    = mean_q[0];
  assign tile.mean_green  = mean_q[1];
  assign tile.mean_blue   = mean_q[2];
  assign tile.mean_alpha  = mean_q[3];

endmodule

`default_nettype wire

### bench/tile_mean_color_check.sv
// Prediction and comparison for the tile mean color unit: tracks register writes,
// keeps its own column sums and tile position, and compares every tile item and read.
// Depends on tmc_pkg and the channel interfaces in tmc_if.
`default_nettype none

module tile_mean_color_check (
  input  logic                       clk,
  input  logic                       rst,
  tmc_pixel_if                       pixel,
  tmc_tile_if                        tile,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [tmc_pkg::ADDR_W-1:0] paddr,
  input  logic [tmc_pkg::DATA_W-1:0] pwdata,
  input  logic [tmc_pkg::DATA_W-1:0] prdata,
  output int                         failures,
  output int                         pending,
  output int                         tiles_seen
);
  import tmc_pkg::*;

  localparam int unsigned SUM_MAX = (1 << SUM_W) - 1;

  typedef struct packed {
    logic [COL_W-1:0] tile_column;
    logic [COL_W-1:0] tile_row;
    logic [PIX_W-1:0] mean_red;
    logic [PIX_W-1:0] mean_green;
    logic [PIX_W-1:0] mean_blue;
    logic [PIX_W-1:0] mean_alpha;
    logic             frame_done;
  } tile_mean_t;

  logic [CFG_DIM_W-1:0] tile_w_reg, tile_h_reg;
  logic [CFG_CNT_W-1:0] cols_reg, rows_reg;
  logic [SUM_W-1:0]     band_sum [LANES][MAX_TILE_COLS];
  logic [DIM_W-1:0]     px_in_tile, line_in_tile;
  logic [COL_W-1:0]     tile_col_pos, tile_row_pos;
  tile_mean_t           mean_queue [$];

  function automatic int unsigned eff_size(int unsigned v, int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic watch_register();
    logic [DATA_W-1:0] held;
    held = '0;
    if (pwrite) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_TILE_WIDTH:  tile_w_reg = pwdata[CFG_DIM_W-1:0];
        REG_TILE_HEIGHT: tile_h_reg = pwdata[CFG_DIM_W-1:0];
        REG_TILE_COLS:   cols_reg   = pwdata[CFG_CNT_W-1:0];
        REG_TILE_ROWS:   rows_reg   = pwdata[CFG_CNT_W-1:0];
        default: ;
      endcase
    end else begin
      case (reg_idx_t'(paddr[3:2]))
        REG_TILE_WIDTH:  held = DATA_W'(tile_w_reg);
        REG_TILE_HEIGHT: held = DATA_W'(tile_h_reg);
        REG_TILE_COLS:   held = DATA_W'(cols_reg);
        REG_TILE_ROWS:   held = DATA_W'(rows_reg);
        default: ;
      endcase
      failures += field_diff("prdata", held, prdata);
    end
  endtask

  // one accepted pixel: update the column sums and the position, queue a mean on tile end
  task automatic take_pixel();
    int unsigned      w, h, nc, nr, area, s, q;
    logic [COL_W-1:0] c;
    logic             fresh, last_px, last_line, last_col, last_row;
    logic [PIX_W-1:0] chan [LANES];
    logic [PIX_W-1:0] m [LANES];
    tile_mean_t       t;
    w  = eff_size(tile_w_reg, MAX_TILE_DIM);
    h  = eff_size(tile_h_reg, MAX_TILE_DIM);
    nc = eff_size(cols_reg, MAX_TILE_COLS);
    nr = eff_size(rows_reg, ROW_LIMIT);
    chan = '{pixel.red, pixel.green, pixel.blue, pixel.alpha};
    if (pixel.frame_start) begin
      px_in_tile   = '0;
      line_in_tile = '0;
      tile_col_pos = '0;
      tile_row_pos = '0;
    end
    c = tile_col_pos;
    fresh = (px_in_tile == 0) && (line_in_tile == 0);
    for (int i = 0; i < LANES; i++) begin
      s = fresh ? chan[i] : band_sum[i][c] + chan[i];
      if (s > SUM_MAX) s = SUM_MAX;
      band_sum[i][c] = SUM_W'(s);
    end
    last_px   = int'(px_in_tile) >= int'(w) - 1;
    last_line = int'(line_in_tile) >= int'(h) - 1;
    last_col  = int'(tile_col_pos) >= int'(nc) - 1;
    last_row  = int'(tile_row_pos) >= int'(nr) - 1;
    if (last_px && last_line) begin
      area = w * h;
      for (int i = 0; i < LANES; i++) begin
        q = band_sum[i][c] / area;
        m[i] = (q > 255) ? 8'hFF : PIX_W'(q);
      end
      t.tile_column = tile_col_pos;
      t.tile_row    = tile_row_pos;
      t.mean_red    = m[0];
      t.mean_green  = m[1];
      t.mean_blue   = m[2];
      t.mean_alpha  = m[3];
      t.frame_done  = last_col && last_row;
      mean_queue.insert(mean_queue.size(), t);
    end
    if (!last_px) begin
      px_in_tile = px_in_tile + 1'b1;
    end else begin
      px_in_tile = '0;
      if (!last_col) begin
        tile_col_pos = tile_col_pos + 1'b1;
      end else begin
        tile_col_pos = '0;
        if (!last_line) begin
          line_in_tile = line_in_tile + 1'b1;
        end else begin
          line_in_tile = '0;
          tile_row_pos = last_row ? '0 : tile_row_pos + 1'b1;
        end
      end
    end
  endtask

  task automatic take_tile();
    tile_mean_t want;
    tiles_seen++;
    if (mean_queue.size() == 0) begin
      $error("tile item at column %0d row %0d with no mean pending",
             tile.tile_column, tile.tile_row);
      failures++;
      return;
    end
    want = mean_queue.pop_front();
    failures += field_diff("tile_column", want.tile_column, tile.tile_column)
              + field_diff("tile_row", want.tile_row, tile.tile_row)
              + field_diff("mean_red", want.mean_red, tile.mean_red)
              + field_diff("mean_green", want.mean_green, tile.mean_green)
              + field_diff("mean_blue", want.mean_blue, tile.mean_blue)
              + field_diff("mean_alpha", want.mean_alpha, tile.mean_alpha)
              + field_diff("frame_done", want.frame_done, tile.frame_done);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tile_w_reg   = 7'd32;
      tile_h_reg   = 7'd32;
      cols_reg     = 10'd20;
      rows_reg     = 10'd20;
      px_in_tile   = '0;
      line_in_tile = '0;
      tile_col_pos = '0;
      tile_row_pos = '0;
      mean_queue.delete();
      failures     = 0;
      tiles_seen   = 0;
    end else begin
      if (psel && penable && pready) watch_register();
      if (tile.valid && tile.ready) take_tile();
      if (pixel.valid && pixel.ready) take_pixel();
    end
    pending = mean_queue.size();
  end

endmodule

`default_nettype wire

### bench/tile_mean_color_unit_tb.sv
// Top of the tile mean color bench: clock, reset, register setup, pixel stimulus
// with random idling on both channels, watchdog and verdict.
// Depends on tmc_pkg, tmc_if, tile_mean_color_unit and tile_mean_color_check.
`default_nettype none

module tile_mean_color_unit_tb;
  import tmc_pkg::*;

  localparam int PIXEL_TOTAL   = 1700;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;

  logic              clk, rst;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  int                failures, pending, tiles_seen;
  int                sent = 0;
  int                settings = 0;
  int                send_idle_pct = 26;
  int                recv_idle_pct = 67;
  int                idle_cycles = 0;
  int unsigned       cols_in_use = 20;
  logic              frame_start_due = 1'b0;

  tmc_pixel_if pixel ();
  tmc_tile_if  tile ();

  tile_mean_color_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pixel),
    .tile    (tile),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tile_mean_color_check u_check (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .tile       (tile),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .failures   (failures),
    .pending    (pending),
    .tiles_seen (tiles_seen)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(negedge clk) begin
    tile.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((pixel.valid && pixel.ready) || (tile.valid && tile.ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $error("no item moved for %0d cycles, %0d means still pending", STALL_LIMIT, pending);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [PIX_W-1:0] level();
    int unsigned r;
    r = $urandom_range(99);
    return (r < 10) ? 8'h00 : ((r < 20) ? 8'hFF : PIX_W'($urandom()));
  endfunction

  function automatic logic [4*PIX_W-1:0] rgba_random();
    return {level(), level(), level(), level()};
  endfunction

  function automatic int unsigned pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(65, 127);
    if (r < 22) return $urandom_range(5, 64);
    return $urandom_range(1, 4);
  endfunction

  function automatic int unsigned pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return 0;
    if (r < 10) return $urandom_range(513, 1023);
    if (r < 18) return $urandom_range(7, 512);
    return $urandom_range(1, 6);
  endfunction

  // unused upper bits carry noise, the register must ignore them
  function automatic logic [DATA_W-1:0] with_noise(logic [DATA_W-1:0] mask, int unsigned v);
    return ($urandom() & ~mask) | (v & mask);
  endfunction

  task automatic apb_access(logic wr, reg_idx_t idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = ADDR_W'({idx, 2'b00});
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic settle();
    pixel.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_tiles(int unsigned w, int unsigned h, int unsigned cols, int unsigned rows);
    int unsigned new_cols;
    settle();
    apb_access(1'b1, REG_TILE_WIDTH, with_noise(32'h7F, w));
    apb_access(1'b1, REG_TILE_HEIGHT, with_noise(32'h7F, h));
    apb_access(1'b1, REG_TILE_COLS, with_noise(32'h3FF, cols));
    apb_access(1'b1, REG_TILE_ROWS, with_noise(32'h3FF, rows));
    apb_access(1'b0, REG_TILE_WIDTH, '0);
    apb_access(1'b0, REG_TILE_HEIGHT, '0);
    apb_access(1'b0, REG_TILE_COLS, '0);
    apb_access(1'b0, REG_TILE_ROWS, '0);
    // more columns than before: restart the frame so no unwritten column sum is read
    new_cols = (cols == 0) ? 1 : ((cols > MAX_TILE_COLS) ? MAX_TILE_COLS : cols);
    if (new_cols > cols_in_use) frame_start_due = 1'b1;
    cols_in_use = new_cols;
    settings++;
  endtask

  task automatic send_pixel(logic [4*PIX_W-1:0] rgba, logic fs);
    if (sent < PIXEL_TOTAL / 3) begin
      send_idle_pct = 26;
      recv_idle_pct = 67;
    end else if (sent < 2 * PIXEL_TOTAL / 3) begin
      send_idle_pct = 67;
      recv_idle_pct = 26;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      pixel.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    {pixel.red, pixel.green, pixel.blue, pixel.alpha} = rgba;
    pixel.frame_start = fs | frame_start_due;
    frame_start_due   = 1'b0;
    pixel.valid       = 1'b1;
    @(posedge clk);
    while (!pixel.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  initial begin
    int unsigned n;
    int          phase;
    logic        sweep;
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    pixel.valid       = 1'b0;
    pixel.red         = '0;
    pixel.green       = '0;
    pixel.blue        = '0;
    pixel.alpha       = '0;
    pixel.frame_start = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // 2x1 tiles in a 2x2 grid: full frame plus wrap into the next one
    set_tiles(2, 1, 2, 2);
    for (int k = 0; k < 10; k++)
      send_pixel((k == 1) ? '1 : ((k == 2) ? '0 : rgba_random()), k == 0);
    // zero dimensions act as one: every pixel ends a frame
    set_tiles(0, 0, 0, 0);
    for (int k = 0; k < 3; k++) send_pixel(rgba_random(), 1'b0);
    // oversized registers, then width shrinks mid-tile: mean saturates
    set_tiles(127, 1, 1023, 1023);
    for (int k = 0; k < 3; k++) send_pixel({4{8'd150}}, k == 0);
    set_tiles(1, 1, 1023, 1023);
    for (int k = 0; k < 2; k++) send_pixel({4{8'd150}}, 1'b0);
    // height shrinks while the line counter is past the new limit
    set_tiles(1, 64, 1, 1);
    for (int k = 0; k < 3; k++) send_pixel(rgba_random(), k == 0);
    set_tiles(1, 1, 1, 1);
    send_pixel(rgba_random(), 1'b0);

    phase = 0;
    while (sent < PIXEL_TOTAL) begin
      sweep = 1'b1;
      if (phase == 0) begin
        set_tiles(1, 1, 1023, 1);
        n = 520;
      end else if (phase == 3) begin
        set_tiles(1, 1, 1, 1023);
        n = 515;
      end else begin
        set_tiles(pick_dim(), pick_dim(), pick_count(), pick_count());
        n = $urandom_range(40, 160);
        sweep = 1'b0;
      end
      for (int k = 0; k < n; k++)
        send_pixel(rgba_random(), (k == 0 && sweep) || ($urandom_range(79) == 0));
      phase++;
    end

    settle();
    $display("covered %0d pixels over %0d register settings, %0d tile means compared",
             sent, settings, tiles_seen);
    $display("included zero and oversized registers, full column and row sweeps, frame wrap");
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hw/rtl/tmc_pkg.sv
hw/rtl/tmc_if.sv
hw/rtl/tmc_cfg.sv
hw/rtl/tmc_lane.sv
hw/rtl/tmc_ctrl.sv
hw/rtl/tile_mean_color_unit.sv
bench/tile_mean_color_check.sv
bench/tile_mean_color_unit_tb.sv
